// ===== sv/bitmap_page_allocator_macros.svh =====
// Assertion helpers for the page allocator checker.
// Each expects clk and rst_n in scope.
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bpa_pkg.sv =====
`default_nettype none

package bpa_pkg;

  localparam int MAX_PAGES = 4096;
  localparam int PG_W      = $clog2(MAX_PAGES);
  localparam int LIM_W     = PG_W + 1;

  // Request and result field widths.
  localparam int FIRST_W   = 12;
  localparam int LEN_W     = 13;
  localparam int PCNT_W    = 13;
  localparam int STAT_W    = 2;

  // Bitmap storage: one RAM row holds the used bits of ROW_BITS pages.
  localparam int ROW_BITS  = 32;
  localparam int BIT_W     = $clog2(ROW_BITS);
  localparam int ROWS      = MAX_PAGES / ROW_BITS;
  localparam int ROW_AW    = $clog2(ROWS);

  // APB register file.
  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = 32;
  localparam logic [CFG_AW-1:0] REG_PAGE_COUNT = CFG_AW'(0);
  localparam logic [PCNT_W-1:0] PAGE_COUNT_RST = PCNT_W'(MAX_PAGES);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 2'd0,
    ST_NO_RUN = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SREAD,
    S_SCAN,
    S_MREAD,
    S_MWRITE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic fail_alloc;
    logic begin_scan;
    logic begin_free;
    logic free_out;
    logic rd;
    logic scan_step;
    logic wr;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic op_free;
    logic alloc_bad;
    logic len_zero;
    logic first_out;
    logic hit;
    logic last;
    logic row_end;
    logic last_row;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== sv/bpa_if.sv =====
`default_nettype none

interface bpa_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [bpa_pkg::FIRST_W-1:0]  first_page;
  logic [bpa_pkg::LEN_W-1:0]    run_length;

  modport source (output valid, op, first_page, run_length, input ready);
  modport sink   (input valid, op, first_page, run_length, output ready);
endinterface

interface bpa_out_if;
  logic                         valid;
  logic                         ready;
  logic [bpa_pkg::STAT_W-1:0]   status;
  logic [bpa_pkg::FIRST_W-1:0]  base_page;

  modport source (output valid, status, base_page, input ready);
  modport sink   (input valid, status, base_page, output ready);
endinterface

`default_nettype wire

// ===== sv/bpa_ram.sv =====
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/bpa_ctrl.sv =====
`default_nettype none

module bpa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire bpa_pkg::stat_t st,
  output bpa_pkg::cmd_t       cmd
);

  bpa_pkg::state_t state_r;
  bpa_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpa_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = bpa_pkg::S_CHECK;
        end
      end
      bpa_pkg::S_CHECK: begin
        if (st.op_free) begin
          if (st.len_zero || st.first_out) begin
            state_nxt = bpa_pkg::S_RESP;
          end else begin
            state_nxt = bpa_pkg::S_MREAD;
          end
        end else if (st.alloc_bad) begin
          state_nxt = bpa_pkg::S_RESP;
        end else begin
          state_nxt = bpa_pkg::S_SREAD;
        end
      end
      bpa_pkg::S_SREAD: state_nxt = bpa_pkg::S_SCAN;
      bpa_pkg::S_SCAN: begin
        if (st.hit) begin
          state_nxt = bpa_pkg::S_MREAD;
        end else if (st.last) begin
          state_nxt = bpa_pkg::S_RESP;
        end else if (st.row_end) begin
          state_nxt = bpa_pkg::S_SREAD;
        end
      end
      bpa_pkg::S_MREAD: state_nxt = bpa_pkg::S_MWRITE;
      bpa_pkg::S_MWRITE: begin
        if (st.last_row) begin
          state_nxt = bpa_pkg::S_RESP;
        end else begin
          state_nxt = bpa_pkg::S_MREAD;
        end
      end
      bpa_pkg::S_RESP: begin
        if (st.out_free) begin
          state_nxt = bpa_pkg::S_IDLE;
        end
      end
      default: state_nxt = bpa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      bpa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      bpa_pkg::S_CHECK: begin
        if (st.op_free) begin
          if (!st.len_zero) begin
            cmd.free_out   = st.first_out;
            cmd.begin_free = !st.first_out;
          end
        end else begin
          cmd.fail_alloc = st.alloc_bad;
          cmd.begin_scan = !st.alloc_bad;
        end
      end
      bpa_pkg::S_SREAD:  cmd.rd        = 1'b1;
      bpa_pkg::S_SCAN:   cmd.scan_step = 1'b1;
      bpa_pkg::S_MREAD:  cmd.rd        = 1'b1;
      bpa_pkg::S_MWRITE: cmd.wr        = 1'b1;
      bpa_pkg::S_RESP:   cmd.emit      = st.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/bpa_dp.sv =====
`default_nettype none

module bpa_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bpa_pkg::cmd_t                 cmd,
  output bpa_pkg::stat_t                     st,
  input  wire logic                          in_op,
  input  wire logic [bpa_pkg::FIRST_W-1:0]   in_first_page,
  input  wire logic [bpa_pkg::LEN_W-1:0]     in_run_length,
  input  wire logic [bpa_pkg::PCNT_W-1:0]    page_count,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic      [bpa_pkg::STAT_W-1:0]    out_status,
  output logic      [bpa_pkg::FIRST_W-1:0]   out_base_page
);

  localparam int PG_W     = bpa_pkg::PG_W;
  localparam int LIM_W    = bpa_pkg::LIM_W;
  localparam int BIT_W    = bpa_pkg::BIT_W;
  localparam int ROW_BITS = bpa_pkg::ROW_BITS;
  localparam int ROW_AW   = bpa_pkg::ROW_AW;
  localparam int ROWS     = bpa_pkg::ROWS;
  localparam int LEN_W    = bpa_pkg::LEN_W;
  localparam int FIRST_W  = bpa_pkg::FIRST_W;

  // Request and working registers.
  bpa_pkg::op_t             op_r;
  logic [FIRST_W-1:0]       first_r;
  logic [LEN_W-1:0]         len_r;
  logic [PG_W-1:0]          pg_r;
  logic [LEN_W-1:0]         found_r;
  logic [ROW_AW-1:0]        row_r;
  logic [PG_W-1:0]          lo_r;
  logic [PG_W-1:0]          hi_r;
  logic                     set_r;
  logic                     rv_r;
  logic [ROWS-1:0]          row_valid_r;
  bpa_pkg::status_t         res_status_r;
  logic [FIRST_W-1:0]       res_start_r;
  logic                     out_valid_r;
  bpa_pkg::status_t         out_status_r;
  logic [FIRST_W-1:0]       out_start_r;

  logic [LIM_W-1:0]         limit;
  logic [ROW_BITS-1:0]      rd_data;
  logic [ROW_BITS-1:0]      word;
  logic                     cur_bit;
  logic [LEN_W-1:0]         found_inc;
  logic                     hit;
  logic                     last;
  logic                     row_end;
  logic [PG_W-1:0]          run_lo;
  logic [LIM_W:0]           free_sum;
  logic                     over;
  logic [PG_W-1:0]          free_end;
  logic                     last_row;
  logic [BIT_W-1:0]         lo_b;
  logic [BIT_W-1:0]         hi_b;
  logic [ROW_BITS-1:0]      mask;
  logic [ROW_BITS-1:0]      wr_data;
  logic                     out_free;

  assign limit = (page_count > bpa_pkg::PCNT_W'(bpa_pkg::MAX_PAGES)) ?
                 LIM_W'(bpa_pkg::MAX_PAGES) : LIM_W'(page_count);

  // A row never written reads as all pages used, through its cleared valid flag.
  assign word      = rv_r ? rd_data : {ROW_BITS{1'b1}};
  assign cur_bit   = word[pg_r[BIT_W-1:0]];
  assign found_inc = found_r + 1'b1;
  assign hit       = !cur_bit && (found_inc == len_r);
  assign last      = ({1'b0, pg_r} == (limit - 1'b1));
  assign row_end   = &pg_r[BIT_W-1:0];
  assign run_lo    = pg_r - PG_W'(len_r) + 1'b1;

  assign free_sum  = (LIM_W+1)'(first_r) + (LIM_W+1)'(len_r);
  assign over      = free_sum > (LIM_W+1)'(limit);
  assign free_end  = over ? PG_W'(limit - 1'b1) : PG_W'(free_sum - 1'b1);

  // Bit range of the current row that falls inside [lo_r, hi_r].
  assign last_row  = (row_r == hi_r[PG_W-1:BIT_W]);
  assign lo_b      = (row_r == lo_r[PG_W-1:BIT_W]) ? lo_r[BIT_W-1:0] : '0;
  assign hi_b      = last_row ? hi_r[BIT_W-1:0] : {BIT_W{1'b1}};
  assign mask      = ({ROW_BITS{1'b1}} << lo_b) &
                     ({ROW_BITS{1'b1}} >> (BIT_W'(ROW_BITS - 1) - hi_b));
  assign wr_data   = set_r ? (word | mask) : (word & ~mask);

  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    st.op_free   = (op_r == bpa_pkg::OP_FREE);
    st.alloc_bad = (len_r == '0) || (len_r > LEN_W'(limit));
    st.len_zero  = (len_r == '0);
    st.first_out = (LIM_W'(first_r) >= limit);
    st.hit       = hit;
    st.last      = last;
    st.row_end   = row_end;
    st.last_row  = last_row;
    st.out_free  = out_free;
  end

  bpa_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROWS)
  ) u_bitmap (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (row_r),
    .wdata (wr_data),
    .re    (cmd.rd),
    .raddr (row_r),
    .rdata (rd_data)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.wr) begin
        row_valid_r[row_r] <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r         <= bpa_pkg::op_t'(in_op);
      first_r      <= in_first_page;
      len_r        <= in_run_length;
      res_status_r <= bpa_pkg::ST_DONE;
      res_start_r  <= '0;
    end
    if (cmd.fail_alloc) begin
      res_status_r <= bpa_pkg::ST_NO_RUN;
    end
    if (cmd.free_out) begin
      res_status_r <= bpa_pkg::ST_RANGE;
    end
    if (cmd.begin_scan) begin
      pg_r    <= '0;
      found_r <= '0;
      row_r   <= '0;
    end
    if (cmd.begin_free) begin
      lo_r         <= PG_W'(first_r);
      hi_r         <= free_end;
      set_r        <= 1'b0;
      row_r        <= first_r[FIRST_W-1:BIT_W];
      res_status_r <= over ? bpa_pkg::ST_RANGE : bpa_pkg::ST_DONE;
    end
    if (cmd.rd) begin
      rv_r <= row_valid_r[row_r];
    end
    if (cmd.scan_step) begin
      if (hit) begin
        // Run found: switch to marking it used.
        lo_r        <= run_lo;
        hi_r        <= pg_r;
        set_r       <= 1'b1;
        row_r       <= run_lo[PG_W-1:BIT_W];
        res_start_r <= FIRST_W'(run_lo);
      end else if (last) begin
        res_status_r <= bpa_pkg::ST_NO_RUN;
      end else begin
        found_r <= cur_bit ? '0 : found_inc;
        pg_r    <= pg_r + 1'b1;
        if (row_end) begin
          row_r <= row_r + 1'b1;
        end
      end
    end
    if (cmd.wr && !last_row) begin
      row_r <= row_r + 1'b1;
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_start_r  <= res_start_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_base_page = out_start_r;

endmodule

`default_nettype wire

// ===== sv/bitmap_page_allocator.sv =====
// Bitmap first-fit page allocator.
// Requests arrive on in_ch (valid/ready): op 0 allocates run_length pages,
// op 1 frees run_length pages from first_page. Each request yields exactly
// one result on out_ch: status (0 done, 1 no free run, 2 free ran past the
// page count) and base_page of a successful allocation, else 0.
// page_count is written over the APB port at address 0; write it only while
// no request is in flight. Pages at or above min(page_count, 4096) are not
// managed.
// One request is in work at a time. The used bits sit in a 128 x 32 RAM and
// the scan tests one page per cycle, pausing to read in each new row.
// A free reads and rewrites each row it touches; an allocation scans from
// page 0 until a run fits or the page count is reached, then reads and
// rewrites each row of the run. Rejected and empty requests go straight to
// the result.
// Reset (synchronous, rst_n low) marks every page used at once through
// per-row valid flags, so requests are taken on the first cycle after reset.
// A result waits in an output register while out_ch.ready is low; a new
// request is taken then, but its result holds until the register drains.
`default_nettype none

module bitmap_page_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  bpa_in_if.sink                             in_ch,
  bpa_out_if.source                          out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bpa_pkg::CFG_AW-1:0]    paddr,
  input  wire logic [bpa_pkg::CFG_DW-1:0]    pwdata,
  output logic      [bpa_pkg::CFG_DW-1:0]    prdata,
  output logic                               pready
);

  logic [bpa_pkg::PCNT_W-1:0] page_count_r;
  bpa_pkg::cmd_t              cmd;
  bpa_pkg::stat_t             st;
  logic                       reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr == bpa_pkg::REG_PAGE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r <= bpa_pkg::PAGE_COUNT_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      page_count_r <= pwdata[bpa_pkg::PCNT_W-1:0];
    end
  end

  assign prdata = reg_hit ? bpa_pkg::CFG_DW'(page_count_r) : '0;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  bpa_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_op          (in_ch.op),
    .in_first_page  (in_ch.first_page),
    .in_run_length  (in_ch.run_length),
    .page_count     (page_count_r),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_status     (out_ch.status),
    .out_base_page  (out_ch.base_page)
  );

endmodule

`default_nettype wire

// ===== sv/bpa_chk.sv =====
`default_nettype none
`include "bitmap_page_allocator_macros.svh"

module bpa_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [bpa_pkg::STAT_W-1:0]    out_status,
  input wire logic [bpa_pkg::FIRST_W-1:0]   out_base_page
);

  `BPA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_base_page),
    "stalled result changed")

  `BPA_ASSERT_NOW(a_status_code, out_valid,
    out_status == bpa_pkg::ST_DONE || out_status == bpa_pkg::ST_NO_RUN ||
    out_status == bpa_pkg::ST_RANGE,
    "result status code out of range")

  `BPA_ASSERT_NOW(a_fail_zero, out_valid && out_status != bpa_pkg::ST_DONE,
    out_base_page == '0,
    "failed request reports a nonzero base page")

  `BPA_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready,
    "request taken while previous one still in work")

endmodule

bind bitmap_page_allocator bpa_chk u_bpa_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_base_page  (out_ch.base_page)
);

`default_nettype wire

// ===== tb/tb_bitmap_page_allocator.sv =====
`timescale 1ns / 1ps

module tb_bitmap_page_allocator;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int LONG_HOLD   = 500;
  localparam int MAX_PAGES   = bpa_pkg::MAX_PAGES;
  localparam int FIRST_W     = bpa_pkg::FIRST_W;
  localparam int LEN_W       = bpa_pkg::LEN_W;
  localparam int PCNT_W      = bpa_pkg::PCNT_W;
  localparam int CFG_AW      = bpa_pkg::CFG_AW;
  localparam int CFG_DW      = bpa_pkg::CFG_DW;

  typedef struct packed {
    bpa_pkg::op_t       op;
    logic [FIRST_W-1:0] first_page;
    logic [LEN_W-1:0]   run_length;
  } page_request_t;

  typedef struct packed {
    bpa_pkg::status_t   status;
    logic [FIRST_W-1:0] base_page;
  } alloc_outcome_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  bpa_in_if  in_ch();
  bpa_out_if out_ch();

  bitmap_page_allocator uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the block's state and configuration.
  bit [MAX_PAGES-1:0] page_map;
  logic [PCNT_W-1:0]  model_page_count;

  page_request_t  request_q[$];
  alloc_outcome_t outcome_q[$];

  int errors = 0;
  int cycles = 0;
  bit drv_burst = 1'b0;
  bit mon_burst = 1'b0;
  bit long_stall = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, 6);
  endfunction

  // Work out the outcome of one accepted request and update the shadow bitmap.
  function automatic void apply_request(input page_request_t req);
    int lim;
    int found;
    int len;
    int i;
    int j;
    int p;
    bit over;
    alloc_outcome_t res;
    lim = (model_page_count > MAX_PAGES) ? MAX_PAGES : int'(model_page_count);
    len = int'(req.run_length);
    res.status = bpa_pkg::ST_DONE;
    res.base_page = '0;
    if (req.op == bpa_pkg::OP_ALLOC) begin
      res.status = bpa_pkg::ST_NO_RUN;
      found = 0;
      if (len != 0 && len <= lim) begin
        for (i = 0; i < lim && res.status != bpa_pkg::ST_DONE; i++) begin
          if (!page_map[i]) begin
            found++;
            if (found == len) begin
              for (j = i + 1 - len; j <= i; j++) page_map[j] = 1'b1;
              res.status = bpa_pkg::ST_DONE;
              res.base_page = FIRST_W'(i + 1 - len);
            end
          end else begin
            found = 0;
          end
        end
      end
    end else begin
      over = 1'b0;
      for (i = 0; i < len; i++) begin
        p = int'(req.first_page) + i;
        if (p < lim) page_map[p] = 1'b0;
        else over = 1'b1;
      end
      res.status = over ? bpa_pkg::ST_RANGE : bpa_pkg::ST_DONE;
    end
    outcome_q.push_back(res);
  endfunction

  // Request driver.
  page_request_t drv_req;
  int            drv_idle;
  int            drv_gap;
  bit            drv_fire;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.op <= bpa_pkg::OP_ALLOC;
      in_ch.first_page <= '0;
      in_ch.run_length <= '0;
      drv_idle <= 0;
    end else begin
      drv_fire = in_ch.valid && in_ch.ready;
      if (drv_fire) begin
        drv_req.op = bpa_pkg::op_t'(in_ch.op);
        drv_req.first_page = in_ch.first_page;
        drv_req.run_length = in_ch.run_length;
        apply_request(drv_req);
      end
      if (drv_fire || !in_ch.valid) begin
        drv_gap = drv_fire ? draw_gap(drv_burst) : drv_idle;
        if (drv_gap > 0) begin
          in_ch.valid <= 1'b0;
          drv_idle <= drv_gap - 1;
        end else if (request_q.size() > 0) begin
          drv_req = request_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.op <= drv_req.op;
          in_ch.first_page <= drv_req.first_page;
          in_ch.run_length <= drv_req.run_length;
          drv_idle <= 0;
        end else begin
          in_ch.valid <= 1'b0;
          drv_idle <= 0;
        end
      end
    end
  end

  // Long receiver hold-off, armed once by the stimulus.
  int hold_cnt;
  bit hold_off;
  bit stall_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
      hold_off <= 1'b0;
      stall_done <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      hold_off <= (hold_cnt > 1);
    end else if (long_stall && !stall_done) begin
      hold_cnt <= LONG_HOLD;
      hold_off <= 1'b1;
      stall_done <= 1'b1;
    end
  end

  // Result monitor.
  alloc_outcome_t mon_want;
  int             mon_idle;
  int             mon_gap;
  bit             mon_fire;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      mon_idle <= 0;
    end else begin
      mon_fire = out_ch.valid && out_ch.ready;
      if (mon_fire) begin
        if (outcome_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual status=%0d base_page=%0d",
                   $time, out_ch.status, out_ch.base_page);
        end else begin
          mon_want = outcome_q.pop_front();
          if (out_ch.status !== mon_want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, mon_want.status, out_ch.status);
          end
          if (out_ch.base_page !== mon_want.base_page) begin
            errors++;
            $display("%0t: base_page mismatch: expected %0d, actual %0d",
                     $time, mon_want.base_page, out_ch.base_page);
          end
        end
      end
      if (hold_off) begin
        // hold off long enough for the block to back up into its input
        out_ch.ready <= 1'b0;
      end else if (mon_fire) begin
        mon_gap = draw_gap(mon_burst);
        out_ch.ready <= (mon_gap == 0);
        mon_idle <= (mon_gap > 0) ? mon_gap - 1 : 0;
      end else if (mon_idle > 0) begin
        out_ch.ready <= 1'b0;
        mon_idle <= mon_idle - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic apb_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read(input logic [CFG_AW-1:0] addr, output logic [CFG_DW-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_page_count_reg;
    logic [CFG_DW-1:0] rd;
    apb_read(bpa_pkg::REG_PAGE_COUNT, rd);
    if (rd !== CFG_DW'(model_page_count)) begin
      errors++;
      $display("%0t: page_count readback mismatch: expected %0d, actual %0d",
               $time, model_page_count, rd);
    end
  endtask

  task automatic set_page_count(input int value);
    apb_write(bpa_pkg::REG_PAGE_COUNT, CFG_DW'(value));
    model_page_count = PCNT_W'(value);
    check_page_count_reg();
  endtask

  // Block until the driver is empty and every outcome has come back.
  task automatic wait_drained;
    do @(negedge clk);
    while (request_q.size() != 0 || in_ch.valid || outcome_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic push_req(input bpa_pkg::op_t op, input int first, input int len);
    page_request_t r;
    r.op = op;
    r.first_page = FIRST_W'(first);
    r.run_length = LEN_W'(len);
    request_q.push_back(r);
  endtask

  // Mostly small allocations and frees inside the managed range, with some
  // oversized, out-of-range and empty requests mixed in.
  task automatic random_requests(input int n, input int lim);
    int i;
    int pick;
    int span;
    span = (lim < 1) ? 1 : lim;
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 9)
        push_req(bpa_pkg::OP_ALLOC, $urandom_range(0, 4095),
                 $urandom_range(1, (span < 8) ? span : 8));
      else if (pick < 17)
        push_req(bpa_pkg::OP_FREE, $urandom_range(0, span - 1), $urandom_range(1, 12));
      else if (pick == 17)
        push_req(bpa_pkg::OP_ALLOC, $urandom_range(0, 4095), $urandom_range(0, 8191));
      else if (pick == 18)
        push_req(bpa_pkg::OP_FREE, $urandom_range(0, 4095), $urandom_range(0, 4096));
      else
        push_req(($urandom_range(0, 1) == 0) ? bpa_pkg::OP_ALLOC : bpa_pkg::OP_FREE,
                 $urandom_range(0, 4095), 0);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = bpa_pkg::OP_ALLOC;
    in_ch.first_page = '0;
    in_ch.run_length = '0;
    out_ch.ready = 1'b0;
    page_map = '1;
    model_page_count = bpa_pkg::PAGE_COUNT_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    check_page_count_reg();

    // Directed: everything starts used, so carve out room by freeing first.
    push_req(bpa_pkg::OP_ALLOC, 0, 1);
    push_req(bpa_pkg::OP_ALLOC, 4095, 0);
    push_req(bpa_pkg::OP_FREE, 0, 0);
    push_req(bpa_pkg::OP_FREE, 4095, 0);
    push_req(bpa_pkg::OP_FREE, 0, 16);
    push_req(bpa_pkg::OP_ALLOC, 0, 4);
    push_req(bpa_pkg::OP_ALLOC, 0, 4);
    push_req(bpa_pkg::OP_ALLOC, 0, 9);
    push_req(bpa_pkg::OP_ALLOC, 0, 8);
    push_req(bpa_pkg::OP_FREE, 4090, 10);
    push_req(bpa_pkg::OP_FREE, 4095, 1);
    push_req(bpa_pkg::OP_ALLOC, 0, 6);
    push_req(bpa_pkg::OP_ALLOC, 0, 4096);
    push_req(bpa_pkg::OP_FREE, 0, 4096);
    push_req(bpa_pkg::OP_ALLOC, 4095, 4096);
    push_req(bpa_pkg::OP_ALLOC, 0, 8191);
    push_req(bpa_pkg::OP_FREE, 0, 8191);
    push_req(bpa_pkg::OP_ALLOC, 0, 1);
    push_req(bpa_pkg::OP_FREE, 2048, 1);
    push_req(bpa_pkg::OP_FREE, 4095, 4096);
    push_req(bpa_pkg::OP_FREE, 0, 4096);
    wait_drained();

    set_page_count(64);
    random_requests(25, 64);
    wait_drained();
    long_stall = 1'b1;
    random_requests(25, 64);
    wait_drained();

    set_page_count(8191);
    random_requests(15, 4096);
    wait_drained();

    set_page_count(0);
    push_req(bpa_pkg::OP_ALLOC, 0, 1);
    push_req(bpa_pkg::OP_ALLOC, 0, 0);
    push_req(bpa_pkg::OP_FREE, 0, 1);
    push_req(bpa_pkg::OP_FREE, 5, 0);
    push_req(bpa_pkg::OP_FREE, 4095, 4096);
    random_requests(6, 0);
    wait_drained();

    set_page_count(1);
    random_requests(10, 1);
    wait_drained();

    set_page_count(4096);
    random_requests(15, 4096);
    wait_drained();

    // back-to-back on both sides
    drv_burst = 1'b1;
    mon_burst = 1'b1;
    set_page_count(100);
    random_requests(20, 100);
    wait_drained();

    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/bpa_pkg.sv
sv/bpa_if.sv
sv/bpa_ram.sv
sv/bpa_ctrl.sv
sv/bpa_dp.sv
sv/bitmap_page_allocator.sv
sv/bpa_chk.sv
tb/tb_bitmap_page_allocator.sv
